/* sv/dpct_pkg.sv */
// Shared constants and types for the dirty page checkpoint tracker.
// Used by the generic RAM wrapper's users and the top level; no dependencies.
package dpct_pkg;

    localparam int MAX_PAGES    = 4096;
    localparam int ADDRESS_BITS = 48;
    localparam int PAGE_W       = $clog2(MAX_PAGES);
    localparam int CNT_W        = PAGE_W + 1;
    localparam int LIST_AW      = PAGE_W + 1;

    localparam int BASE_W  = 48;
    localparam int PAGES_W = 13;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd2;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

    localparam logic [1:0] OP_FAULT = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [2:0] ST_NEW_DIRTY = 3'd0;
    localparam logic [2:0] ST_ALREADY   = 3'd1;
    localparam logic [2:0] ST_OUTSIDE   = 3'd2;
    localparam logic [2:0] ST_STARTED   = 3'd3;
    localparam logic [2:0] ST_REFUSED   = 3'd4;
    localparam logic [2:0] ST_DRAINED   = 3'd5;
    localparam logic [2:0] ST_SKIPPED   = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CALC  = 6'b000100,
        S_DREAD = 6'b001000,
        S_LWAIT = 6'b010000,
        S_EXEC  = 6'b100000
    } state_t;

endpackage

/* sv/dirty_page_checkpoint_tracker_unit.sv */
// Top level of the dirty page checkpoint tracker: control, registers and two RAMs.
// Depends on dpct_pkg and dpct_ram.
//
// An item is taken when start is high and busy is low; its result shows on the
// result ports for one cycle with done high, and the receiver cannot stall it.
// A write fault passes through CALC, DREAD and EXEC, a drain through LWAIT and EXEC
// and a start straight to EXEC; a fault or drain waits for the registered read of
// the dirty bitmap RAM (and, for a drain, first the page list RAM) before the
// write back. busy falls in the cycle the result shows, so the next item can be
// taken then. Operation code 3 is taken, gives no result and leaves busy low.
// After reset the block clears the dirty bitmap one page a cycle with busy high;
// configuration writes are taken at any time (cfg_ready is always high).
module dirty_page_checkpoint_tracker_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          operation,
    input  logic [dpct_pkg::ADDRESS_BITS-1:0]   fault_address,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpct_pkg::BASE_W-1:0]         cfg_data,
    output logic                                done,
    output logic [2:0]                          status,
    output logic [dpct_pkg::PAGE_W-1:0]         page_number,
    output logic                                copy_page,
    output logic [dpct_pkg::CNT_W-1:0]          modified_count,
    output logic [dpct_pkg::CNT_W-1:0]          drain_written_count,
    output logic [dpct_pkg::CNT_W-1:0]          demand_written_count
);

    localparam int AB  = dpct_pkg::ADDRESS_BITS;
    localparam int PW  = dpct_pkg::PAGE_W;
    localparam int CW  = dpct_pkg::CNT_W;
    localparam int LAW = dpct_pkg::LIST_AW;
    localparam logic [CW-1:0] MAX_CNT = CW'(dpct_pkg::MAX_PAGES);

    dpct_pkg::state_t state_reg, state_next;

    logic [dpct_pkg::BASE_W-1:0]  region_base_reg;
    logic [dpct_pkg::PAGES_W-1:0] region_pages_reg;
    logic [dpct_pkg::SHIFT_W-1:0] page_shift_reg;

    logic [1:0]    op_reg, op_next;
    logic [AB-1:0] addr_reg, addr_next;
    logic [PW-1:0] page_reg, page_next;
    logic          outside_reg, outside_next;
    logic [PW-1:0] clear_cnt_reg, clear_cnt_next;

    logic          bank_reg, bank_next;
    logic [CW-1:0] list_len_reg [2];
    logic [CW-1:0] list_len_next [2];
    logic [CW-1:0] drain_idx_reg, drain_idx_next;
    logic [CW-1:0] drain_cnt_reg, drain_cnt_next;
    logic [CW-1:0] demand_cnt_reg, demand_cnt_next;

    logic          done_reg;
    logic [2:0]    status_reg;
    logic [PW-1:0] page_out_reg;
    logic          copy_reg;
    logic [CW-1:0] mod_out_reg, drain_out_reg, demand_out_reg;

    // Result of the execute step.
    logic          res_we;
    logic [2:0]    res_status;
    logic [PW-1:0] res_page;
    logic          res_copy;
    logic [CW-1:0] res_len;

    // Dirty bitmap RAM: one word per page, bit b is the bank b dirty bit.
    logic          dirty_we;
    logic [PW-1:0] dirty_waddr, dirty_raddr;
    logic [1:0]    dirty_wdata, dirty_rdata;

    logic           list_we;
    logic [LAW-1:0] list_waddr, list_raddr;
    logic [PW-1:0]  list_rdata;

    // Region check.
    logic [AB:0]   diff;
    logic [AB-1:0] shifted;
    logic [CW-1:0] limit;
    logic          in_region;

    logic          cur, prog;
    logic [CW-1:0] len_cur, len_prog;
    logic [1:0]    bits;

    dpct_ram #(
        .WIDTH (2),
        .DEPTH (dpct_pkg::MAX_PAGES)
    ) u_dirty_ram (
        .clk   (clk),
        .we    (dirty_we),
        .waddr (dirty_waddr),
        .wdata (dirty_wdata),
        .raddr (dirty_raddr),
        .rdata (dirty_rdata)
    );

    dpct_ram #(
        .WIDTH (PW),
        .DEPTH (2 * dpct_pkg::MAX_PAGES)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (page_reg),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    assign cur      = bank_reg;
    assign prog     = ~bank_reg;
    assign len_cur  = list_len_reg[cur];
    assign len_prog = list_len_reg[prog];

    assign diff      = {1'b0, addr_reg} - {1'b0, region_base_reg};
    assign shifted   = diff[AB-1:0] >> page_shift_reg;
    assign limit     = (region_pages_reg > MAX_CNT) ? MAX_CNT : region_pages_reg;
    assign in_region = !diff[AB] && (shifted < {{(AB-CW){1'b0}}, limit});

    assign dirty_raddr = (state_reg == dpct_pkg::S_DREAD) ? page_reg : list_rdata;
    assign list_raddr  = {prog, drain_idx_reg[PW-1:0]};
    assign list_waddr  = {cur, len_cur[PW-1:0]};

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        page_next        = page_reg;
        outside_next     = outside_reg;
        clear_cnt_next   = clear_cnt_reg;
        bank_next        = bank_reg;
        list_len_next[0] = list_len_reg[0];
        list_len_next[1] = list_len_reg[1];
        drain_idx_next   = drain_idx_reg;
        drain_cnt_next   = drain_cnt_reg;
        demand_cnt_next  = demand_cnt_reg;
        dirty_we         = 1'b0;
        dirty_waddr      = page_reg;
        dirty_wdata      = 2'b00;
        list_we          = 1'b0;
        res_we           = 1'b0;
        res_status       = dpct_pkg::ST_NEW_DIRTY;
        res_page         = '0;
        res_copy         = 1'b0;
        res_len          = len_prog;
        bits             = dirty_rdata;

        case (state_reg)
            dpct_pkg::S_CLEAR:
            begin
                dirty_we       = 1'b1;
                dirty_waddr    = clear_cnt_reg;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == {PW{1'b1}})
                begin
                    state_next = dpct_pkg::S_IDLE;
                end
            end
            dpct_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next   = operation;
                    addr_next = fault_address;
                    case (operation)
                        dpct_pkg::OP_FAULT: state_next = dpct_pkg::S_CALC;
                        dpct_pkg::OP_START: state_next = dpct_pkg::S_EXEC;
                        // The list read for this drain is issued in this cycle.
                        dpct_pkg::OP_DRAIN: state_next = dpct_pkg::S_LWAIT;
                        default:            state_next = dpct_pkg::S_IDLE;
                    endcase
                end
            end
            dpct_pkg::S_CALC:
            begin
                page_next    = shifted[PW-1:0];
                outside_next = !in_region;
                state_next   = dpct_pkg::S_DREAD;
            end
            dpct_pkg::S_DREAD:
            begin
                state_next = dpct_pkg::S_EXEC;
            end
            dpct_pkg::S_LWAIT:
            begin
                page_next  = list_rdata;
                state_next = dpct_pkg::S_EXEC;
            end
            dpct_pkg::S_EXEC:
            begin
                res_we     = 1'b1;
                state_next = dpct_pkg::S_IDLE;
                case (op_reg)
                    dpct_pkg::OP_FAULT:
                    begin
                        if (outside_reg)
                        begin
                            res_status = dpct_pkg::ST_OUTSIDE;
                        end
                        else
                        begin
                            res_page = page_reg;
                            if (bits[prog])
                            begin
                                bits[prog]      = 1'b0;
                                demand_cnt_next = demand_cnt_reg + 1'b1;
                                res_copy        = 1'b1;
                            end
                            if (!bits[cur])
                            begin
                                bits[cur]  = 1'b1;
                                res_status = dpct_pkg::ST_NEW_DIRTY;
                                if (len_cur < MAX_CNT)
                                begin
                                    list_we            = 1'b1;
                                    list_len_next[cur] = len_cur + 1'b1;
                                end
                            end
                            else
                            begin
                                res_status = dpct_pkg::ST_ALREADY;
                            end
                            dirty_we    = 1'b1;
                            dirty_wdata = bits;
                        end
                    end
                    dpct_pkg::OP_START:
                    begin
                        if (len_prog != '0)
                        begin
                            res_status = dpct_pkg::ST_REFUSED;
                        end
                        else
                        begin
                            res_status     = dpct_pkg::ST_STARTED;
                            res_len        = len_cur;
                            bank_next      = prog;
                            drain_idx_next = '0;
                        end
                    end
                    default:
                    begin
                        if (drain_idx_reg < len_prog)
                        begin
                            res_page = page_reg;
                            if (bits[prog])
                            begin
                                bits[prog]     = 1'b0;
                                drain_cnt_next = drain_cnt_reg + 1'b1;
                                res_status     = dpct_pkg::ST_DRAINED;
                                res_copy       = 1'b1;
                            end
                            else
                            begin
                                res_status = dpct_pkg::ST_SKIPPED;
                            end
                            drain_idx_next = drain_idx_reg + 1'b1;
                            dirty_we       = 1'b1;
                            dirty_wdata    = bits;
                        end
                        else
                        begin
                            // End of checkpoint: report the counts, then clear them.
                            res_status          = dpct_pkg::ST_DONE;
                            list_len_next[prog] = '0;
                            drain_cnt_next      = '0;
                            demand_cnt_next     = '0;
                            drain_idx_next      = '0;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = dpct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dpct_pkg::S_CLEAR;
            clear_cnt_reg    <= '0;
            bank_reg         <= 1'b0;
            list_len_reg[0]  <= '0;
            list_len_reg[1]  <= '0;
            drain_idx_reg    <= '0;
            drain_cnt_reg    <= '0;
            demand_cnt_reg   <= '0;
            done_reg         <= 1'b0;
            region_base_reg  <= '0;
            region_pages_reg <= '0;
            page_shift_reg   <= dpct_pkg::PAGE_SHIFT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            clear_cnt_reg   <= clear_cnt_next;
            bank_reg        <= bank_next;
            list_len_reg[0] <= list_len_next[0];
            list_len_reg[1] <= list_len_next[1];
            drain_idx_reg   <= drain_idx_next;
            drain_cnt_reg   <= drain_cnt_next;
            demand_cnt_reg  <= demand_cnt_next;
            done_reg        <= res_we;
            if (cfg_valid)
            begin
                case (cfg_index)
                    dpct_pkg::CFG_REGION_BASE:  region_base_reg  <= cfg_data;
                    dpct_pkg::CFG_REGION_PAGES: region_pages_reg <=
                        cfg_data[dpct_pkg::PAGES_W-1:0];
                    dpct_pkg::CFG_PAGE_SHIFT:   page_shift_reg   <=
                        cfg_data[dpct_pkg::SHIFT_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        page_reg    <= page_next;
        outside_reg <= outside_next;
        if (res_we)
        begin
            status_reg     <= res_status;
            page_out_reg   <= res_page;
            copy_reg       <= res_copy;
            mod_out_reg    <= res_len;
            if (res_status == dpct_pkg::ST_DONE)
            begin
                drain_out_reg  <= drain_cnt_reg;
                demand_out_reg <= demand_cnt_reg;
            end
            else
            begin
                drain_out_reg  <= drain_cnt_next;
                demand_out_reg <= demand_cnt_next;
            end
        end
    end

    assign busy                 = (state_reg != dpct_pkg::S_IDLE);
    assign cfg_ready            = 1'b1;
    assign done                 = done_reg;
    assign status               = status_reg;
    assign page_number          = page_out_reg;
    assign copy_page            = copy_reg;
    assign modified_count       = mod_out_reg;
    assign drain_written_count  = drain_out_reg;
    assign demand_written_count = demand_out_reg;

endmodule

/* sv/dpct_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module dpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
